@@ src/b91_pkg.sv @@
package b91_pkg;

    typedef logic [13:0] b91_val_t;
    typedef logic [6:0]  b91_digit_t;
    typedef logic [7:0]  b91_quot_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } b91_in_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_run;
    } b91_out_t;

    // Word from the front end: raw values still to be split into digits
    typedef struct packed {
        logic       pair_en;
        b91_val_t   pair_val;
        logic       eos;
        logic [1:0] flush_n;
        b91_val_t   flush_val;
    } b91_raw_job_t;

    // Word in the queue: everything the back end needs to emit
    typedef struct packed {
        logic       pair_en;
        b91_digit_t pair_lo;
        b91_digit_t pair_hi;
        logic       eos;
        logic [1:0] flush_n;
        b91_digit_t fl_lo;
        b91_digit_t fl_hi;
    } b91_job_t;

    localparam logic [4:0]  BYTE_BITS   = 5'd8;
    localparam logic [4:0]  HELD_LIMIT  = 5'd13;
    localparam logic [4:0]  TAKE_SHORT  = 5'd13;
    localparam logic [4:0]  TAKE_LONG   = 5'd14;
    localparam logic [4:0]  FLUSH_WIDE  = 5'd7;
    localparam logic [12:0] SHORT_MIN   = 13'd89;
    localparam logic [6:0]  BASE        = 7'd91;
    localparam logic [6:0]  LINE_LEN    = 7'd78;
    localparam logic [6:0]  NEWLINE     = 7'd10;

    // floor(v / 91) == (v * 11523) >> 20 for every 14-bit v
    localparam logic [13:0] RECIP       = 14'd11523;
    localparam int          RECIP_SHIFT = 20;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    function automatic b91_digit_t alpha_char(b91_digit_t idx);
        b91_digit_t ch;
        if (idx < 7'd26) begin
            ch = idx + 7'd65;
        end else if (idx < 7'd52) begin
            ch = idx + 7'd71;
        end else if (idx < 7'd62) begin
            ch = idx - 7'd4;
        end else begin
            case (idx)
                7'd62:   ch = 7'd33;  // !
                7'd63:   ch = 7'd35;  // #
                7'd64:   ch = 7'd36;  // $
                7'd65:   ch = 7'd37;  // %
                7'd66:   ch = 7'd38;  // &
                7'd67:   ch = 7'd40;  // (
                7'd68:   ch = 7'd41;  // )
                7'd69:   ch = 7'd42;  // *
                7'd70:   ch = 7'd43;  // +
                7'd71:   ch = 7'd44;  // ,
                7'd72:   ch = 7'd46;  // .
                7'd73:   ch = 7'd47;  // /
                7'd74:   ch = 7'd58;  // :
                7'd75:   ch = 7'd59;  // ;
                7'd76:   ch = 7'd60;  // <
                7'd77:   ch = 7'd61;  // =
                7'd78:   ch = 7'd62;  // >
                7'd79:   ch = 7'd63;  // ?
                7'd80:   ch = 7'd64;  // @
                7'd81:   ch = 7'd91;  // [
                7'd82:   ch = 7'd93;  // ]
                7'd83:   ch = 7'd94;  // ^
                7'd84:   ch = 7'd95;  // _
                7'd85:   ch = 7'd96;  // `
                7'd86:   ch = 7'd123; // {
                7'd87:   ch = 7'd124; // |
                7'd88:   ch = 7'd125; // }
                7'd89:   ch = 7'd126; // ~
                7'd90:   ch = 7'd34;  // double quote
                default: ch = 7'd63;
            endcase
        end
        return ch;
    endfunction

endpackage

@@ src/b91_front.sv @@
module b91_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b91_pkg::b91_in_t      s_data,
    output logic                  job_valid,
    input  logic                  job_ready,
    output b91_pkg::b91_raw_job_t job
);
    import b91_pkg::*;

    logic [20:0]  acc_reg, acc_next;
    logic [4:0]   held_reg, held_next;
    logic         job_valid_reg, job_valid_next;
    b91_raw_job_t job_reg, job_next;

    logic        accept;
    logic [20:0] acc_in, acc_rem;
    logic [4:0]  held_in, held_rem;
    logic        pair, short_ok;
    b91_val_t    pair_val;
    logic [1:0]  flush_n;

    assign s_ready   = !job_valid_reg || job_ready;
    assign accept    = s_valid && s_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        acc_in   = acc_reg | ({13'd0, s_data.data_byte} << held_reg);
        held_in  = held_reg + BYTE_BITS;
        pair     = held_in > HELD_LIMIT;
        short_ok = acc_in[12:0] >= SHORT_MIN;
        pair_val = short_ok ? {1'b0, acc_in[12:0]} : acc_in[13:0];
        acc_rem  = acc_in;
        held_rem = held_in;
        if (pair) begin
            acc_rem  = short_ok ? (acc_in >> TAKE_SHORT) : (acc_in >> TAKE_LONG);
            held_rem = held_in - (short_ok ? TAKE_SHORT : TAKE_LONG);
        end
        if (held_rem == 5'd0) begin
            flush_n = 2'd0;
        end else if (held_rem > FLUSH_WIDE || acc_rem >= 21'(BASE)) begin
            flush_n = 2'd2;
        end else begin
            flush_n = 2'd1;
        end
    end

    always_comb begin
        acc_next       = acc_reg;
        held_next      = held_reg;
        job_valid_next = job_valid_reg && !job_ready;
        job_next       = job_reg;
        if (accept) begin
            // a byte that leaves no pair and ends nothing produces no word
            job_valid_next     = pair || s_data.end_of_stream;
            job_next.pair_en   = pair;
            job_next.pair_val  = pair_val;
            job_next.eos       = s_data.end_of_stream;
            job_next.flush_n   = s_data.end_of_stream ? flush_n : 2'd0;
            job_next.flush_val = acc_rem[13:0];
            if (s_data.end_of_stream) begin
                acc_next  = '0;
                held_next = '0;
            end else begin
                acc_next  = acc_rem;
                held_next = held_rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            held_reg      <= '0;
            job_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

endmodule

@@ src/b91_divmod.sv @@
module b91_divmod (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b91_pkg::b91_raw_job_t in_job,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b91_pkg::b91_job_t     out_job
);
    import b91_pkg::*;

    logic         s1_valid_reg, s1_valid_next;
    b91_raw_job_t s1_job_reg;
    b91_quot_t    s1_pq_reg, s1_fq_reg;
    logic         out_valid_reg, out_valid_next;
    b91_job_t     out_job_reg, out_job_next;

    logic [27:0] pair_prod, flush_prod;
    logic        s1_adv, s1_load;
    b91_val_t    pair_rem, flush_rem;

    function automatic b91_digit_t wrap_digit(b91_quot_t q);
        b91_digit_t d;
        if (q >= {1'b0, BASE}) begin
            d = 7'(q - {1'b0, BASE});
        end else begin
            d = q[6:0];
        end
        return d;
    endfunction

    assign s1_adv    = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign s1_load   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_job   = out_job_reg;

    // stage 1: quotient by reciprocal multiply
    always_comb begin
        pair_prod     = in_job.pair_val * RECIP;
        flush_prod    = in_job.flush_val * RECIP;
        s1_valid_next = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    end

    // stage 2: remainder and digit wrap
    always_comb begin
        pair_rem       = s1_job_reg.pair_val - 14'({6'd0, s1_pq_reg} * 14'(BASE));
        flush_rem      = s1_job_reg.flush_val - 14'({6'd0, s1_fq_reg} * 14'(BASE));
        out_valid_next = out_valid_reg && !out_ready;
        out_job_next   = out_job_reg;
        if (s1_valid_reg && s1_adv) begin
            out_valid_next       = 1'b1;
            out_job_next.pair_en = s1_job_reg.pair_en;
            out_job_next.pair_lo = pair_rem[6:0];
            out_job_next.pair_hi = wrap_digit(s1_pq_reg);
            out_job_next.eos     = s1_job_reg.eos;
            out_job_next.flush_n = s1_job_reg.flush_n;
            out_job_next.fl_lo   = flush_rem[6:0];
            out_job_next.fl_hi   = wrap_digit(s1_fq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_job_reg <= in_job;
            s1_pq_reg  <= pair_prod[RECIP_SHIFT +: 8];
            s1_fq_reg  <= flush_prod[RECIP_SHIFT +: 8];
        end
        out_job_reg <= out_job_next;
    end

endmodule

@@ src/b91_queue.sv @@
module b91_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  b91_pkg::b91_job_t in_job,
    output logic              head_valid,
    input  logic              head_pop,
    output b91_pkg::b91_job_t head_job
);
    import b91_pkg::*;

    b91_job_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push, pop;

    assign in_ready   = count_reg != (QPTR_W+1)'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = head_pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

@@ src/b91_back.sv @@
module b91_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    output logic              head_pop,
    input  b91_pkg::b91_job_t head_job,
    output logic              m_valid,
    input  logic              m_ready,
    output b91_pkg::b91_out_t m_data
);
    import b91_pkg::*;

    typedef enum logic [5:0] {
        SL_PAIR_LO = 6'b000001,
        SL_PAIR_HI = 6'b000010,
        SL_NL_PAIR = 6'b000100,
        SL_FL_LO   = 6'b001000,
        SL_FL_HI   = 6'b010000,
        SL_NL_END  = 6'b100000
    } slot_t;

    slot_t      slot_reg, slot_next;
    logic [6:0] col_reg, col_next;
    logic       m_valid_reg, m_valid_next;
    b91_out_t   m_data_reg, m_data_next;

    logic [5:0] ge_mask, cand, pick, later;
    logic [6:0] col_emit;
    logic       out_free, emit, more;
    b91_digit_t ch;

    // slots that produce a character for this word at the given column
    function automatic logic [5:0] appl_mask(b91_job_t j, logic [6:0] col);
        logic [5:0] m;
        m[0] = j.pair_en;
        m[1] = j.pair_en;
        m[2] = j.pair_en && (col >= LINE_LEN);
        m[3] = j.flush_n != 2'd0;
        m[4] = j.flush_n == 2'd2;
        m[5] = j.eos && (col != 7'd0);
        return m;
    endfunction

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        ge_mask  = ~(6'(slot_reg) - 6'd1);
        cand     = appl_mask(head_job, col_reg) & ge_mask & {6{head_valid}};
        pick     = cand & (~cand + 6'd1);
        out_free = !m_valid_reg || m_ready;
        emit     = (cand != 6'd0) && out_free;
        case (pick)
            SL_NL_PAIR, SL_NL_END: col_emit = 7'd0;
            default:               col_emit = col_reg + 7'd1;
        endcase
        case (pick)
            SL_PAIR_LO: ch = alpha_char(head_job.pair_lo);
            SL_PAIR_HI: ch = alpha_char(head_job.pair_hi);
            SL_FL_LO:   ch = alpha_char(head_job.fl_lo);
            SL_FL_HI:   ch = alpha_char(head_job.fl_hi);
            default:    ch = NEWLINE;
        endcase
        // look ahead so the last character carries the flag and the word retires with it
        later    = ~(pick | (pick - 6'd1));
        more     = |(appl_mask(head_job, col_emit) & later);
        head_pop = head_valid && ((emit && !more) || (cand == 6'd0));
    end

    always_comb begin
        slot_next    = slot_reg;
        col_next     = col_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit) begin
            col_next                = col_emit;
            m_valid_next            = 1'b1;
            m_data_next.out_char    = ch;
            m_data_next.last_of_run = !more;
            slot_next               = more ? slot_t'(pick << 1) : SL_PAIR_LO;
        end
        if (head_pop) begin
            slot_next = SL_PAIR_LO;
            if (head_job.eos) begin
                col_next = 7'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= SL_PAIR_LO;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            slot_reg    <= slot_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

@@ src/base91_stream_encoder_top.sv @@
// basE91 stream encoder.
// Input channel s_valid/s_ready/s_data takes one byte per word, with
// end_of_stream set on the last byte of a stream. Output channel
// m_valid/m_ready/m_data gives one ASCII character per word: alphabet
// characters, a newline after every 78 of them, and the flush characters
// plus a closing newline after the last byte. last_of_run marks the final
// character that a given input byte causes.
// An accepted byte passes the front-end job register, the divider stages
// and the queue before its first character leaves the output register. The
// front end takes a byte every cycle while its queue has room; the back end
// sends one character per cycle while m_ready is high, so the sustained rate
// is set by the character count (about 1.23 characters plus newlines a byte).
// A stall on m_ready holds the output word; the four-word queue and the
// divider pipeline then fill and s_ready drops. Reset (aresetn low, sync)
// empties the pipeline and queue and clears the bit accumulator and the
// line column; the next byte starts a new stream, as it does after a byte
// flagged end_of_stream.
module base91_stream_encoder_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  b91_pkg::b91_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output b91_pkg::b91_out_t m_data
);
    import b91_pkg::*;

    logic         raw_valid, raw_ready;
    b91_raw_job_t raw_job;
    logic         dm_valid, dm_ready;
    b91_job_t     dm_job;
    logic         head_valid, head_pop;
    b91_job_t     head_job;

    b91_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (raw_valid),
        .job_ready (raw_ready),
        .job       (raw_job)
    );

    b91_divmod u_divmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (raw_valid),
        .in_ready  (raw_ready),
        .in_job    (raw_job),
        .out_valid (dm_valid),
        .out_ready (dm_ready),
        .out_job   (dm_job)
    );

    b91_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (dm_valid),
        .in_ready   (dm_ready),
        .in_job     (dm_job),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_job   (head_job)
    );

    b91_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_job   (head_job),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ verif/base91_stream_encoder_top_tb.sv @@
module base91_stream_encoder_top_tb;

    localparam int          STALL_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          BYTE_TARGET = 270;
    localparam int          LINE_CHARS  = 78;
    localparam logic [6:0]  LF_CHAR     = 7'd10;
    localparam int          SENDER      = 0;
    localparam int          RECEIVER    = 1;

    // basE91 symbol set, symbol 0 in the top byte
    localparam bit [8*91-1:0] SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&()*+,./:;<=>?@[]^_`{|}~\"";

    typedef struct packed {
        b91_pkg::b91_in_t word;
        bit               drain_first;
    } queued_byte_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    b91_pkg::b91_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    b91_pkg::b91_out_t m_data;

    queued_byte_t      pending_bytes[$];
    b91_pkg::b91_out_t expected_chars[$];

    // encoder state as the block should hold it
    logic [20:0] held_bits  = '0;
    logic [4:0]  held_count = '0;
    logic [6:0]  line_pos   = '0;

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   send_hold = 0;
    int   recv_hold = 0;
    int   stretch_left[2];
    bit   stretch_quiet[2];

    int errors        = 0;
    int quiet_cycles  = 0;
    int bytes_taken   = 0;
    int streams_done  = 0;
    int chars_checked = 0;
    int newlines_seen = 0;
    int most_per_byte = 0;

    base91_stream_encoder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // Draw stretches at random that are either free of idling or full of random waits
    function automatic int pick_wait(int side);
        if (stretch_left[side] == 0) begin
            stretch_left[side]  = $urandom_range(10, 50);
            stretch_quiet[side] = ($urandom_range(0, 2) == 0);
        end
        stretch_left[side]--;
        return stretch_quiet[side] ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic add_byte(input logic [7:0] data_v, input bit eos, input bit drain);
        queued_byte_t item;
        item.word.data_byte     = data_v;
        item.word.end_of_stream = eos;
        item.drain_first        = drain;
        pending_bytes.push_back(item);
    endtask

    task automatic push_char(input logic [6:0] ch);
        b91_pkg::b91_out_t w;
        w.out_char    = ch;
        w.last_of_run = 1'b0;
        expected_chars.push_back(w);
    endtask

    task automatic push_symbol(input int idx);
        int k;
        k = idx % 91;
        line_pos = line_pos + 7'd1;
        push_char(SYMBOLS[8*(90-k) +: 7]);
    endtask

    task automatic encode_byte(input b91_pkg::b91_in_t w);
        logic [13:0]       val;
        int                before_n;
        b91_pkg::b91_out_t tail;
        before_n   = expected_chars.size();
        held_bits  = held_bits | (21'(w.data_byte) << held_count);
        held_count = held_count + 5'd8;
        if (held_count > 5'd13) begin
            // short take unless its low 13 bits fall below 89
            if (held_bits[12:0] >= 13'd89) begin
                val        = {1'b0, held_bits[12:0]};
                held_bits  = held_bits >> 13;
                held_count = held_count - 5'd13;
            end else begin
                val        = held_bits[13:0];
                held_bits  = held_bits >> 14;
                held_count = held_count - 5'd14;
            end
            push_symbol(int'(val) % 91);
            push_symbol(int'(val) / 91);
            if (line_pos >= LINE_CHARS) begin
                push_char(LF_CHAR);
                line_pos = '0;
            end
        end
        if (w.end_of_stream) begin
            if (held_count != 0)
                push_symbol(int'(held_bits) % 91);
            if (held_count > 5'd7 || held_bits >= 21'd91)
                push_symbol((int'(held_bits) / 91) % 91);
            if (line_pos != 0)
                push_char(LF_CHAR);
            held_bits  = '0;
            held_count = '0;
            line_pos   = '0;
            streams_done++;
        end
        if (expected_chars.size() > before_n) begin
            tail = expected_chars.pop_back();
            tail.last_of_run = 1'b1;
            expected_chars.push_back(tail);
        end
        if (expected_chars.size() - before_n > most_per_byte)
            most_per_byte = expected_chars.size() - before_n;
    endtask

    always @(posedge aclk) begin : watch_ports
        b91_pkg::b91_out_t want;
        in_taken  <= aresetn && s_valid && s_ready;
        out_taken <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                chars_checked++;
                if (m_data.out_char == LF_CHAR)
                    newlines_seen++;
                if (expected_chars.size() == 0) begin
                    $error("unexpected word: out_char %0d last_of_run %0d",
                           m_data.out_char, m_data.last_of_run);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.out_char !== want.out_char) begin
                        $error("out_char: expected %0d, got %0d", want.out_char,
                               m_data.out_char);
                        errors++;
                    end
                    if (m_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                               m_data.last_of_run);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                bytes_taken++;
                encode_byte(s_data);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Sender: present the next byte, hold it until taken
    always @(negedge aclk) begin : drive_bytes
        queued_byte_t head;
        if (aresetn) begin
            if (in_taken)
                send_hold = pick_wait(SENDER);
            if (!s_valid || in_taken) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() != 0 &&
                             !(pending_bytes[0].drain_first && expected_chars.size() != 0)) begin
                    head = pending_bytes.pop_front();
                    s_data  <= head.word;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall for a drawn number of cycles after each word
    always @(negedge aclk) begin : drive_ready
        if (aresetn) begin
            if (out_taken)
                recv_hold = pick_wait(RECEIVER);
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int          stream_len;
        int          room;
        logic [7:0]  data_v;
        bit          first_stream;

        // one-byte streams at both extremes
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        // 14-bit takes, then a single flush character
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        // seven bits left over but worth more than 90: two flush characters
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        // nothing left to flush, newline only
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);
        // mixed bit patterns, short takes
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b1, 1'b0);

        first_stream = 1'b1;
        while (pending_bytes.size() < BYTE_TARGET) begin
            stream_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 140)
                                                     : $urandom_range(1, 16);
            room = BYTE_TARGET - pending_bytes.size();
            if (stream_len > room)
                stream_len = room;
            for (int k = 0; k < stream_len; k++) begin
                case ($urandom_range(0, 7))
                    0:       data_v = 8'h00;
                    1:       data_v = 8'hFF;
                    2:       data_v = 8'($urandom_range(0, 3));
                    default: data_v = 8'($urandom);
                endcase
                add_byte(data_v, k == stream_len - 1,
                         k == 0 && (first_stream || $urandom_range(0, 5) == 0));
            end
            first_stream = 1'b0;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid || expected_chars.size() != 0)
            @(negedge aclk);
        // catch any stray word from a byte that should have given none
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Encoded %0d bytes in %0d streams; checked %0d characters, %0d newlines.",
                 bytes_taken, streams_done, chars_checked, newlines_seen);
        $display("Most characters caused by a single byte: %0d", most_per_byte);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
